>>> hdl/tptevq_pkg.sv
// ----------------------------------------------------------------------------
// tptevq_pkg
// Shared constants, codes and types of the touch contact tracker.
// ----------------------------------------------------------------------------
package tptevq_pkg;

  localparam int FIFO_DEPTH   = 4096;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_CONTACTS = 16;
  localparam int SLOT_W       = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

  localparam int ID_W         = 32;
  localparam int POS_W        = 32;
  localparam int KIND_W       = 2;
  localparam int STAT_W       = 3;
  localparam int LVL_W        = 13;

  // slot memory word: {mouse, y, x}
  localparam int SLOT_RAM_W   = POS_W + 1;
  // fifo memory word: {mouse, kind, y, x, id}
  localparam int FIFO_RAM_W   = ID_W + POS_W + KIND_W + 1;

  localparam logic [LVL_W-1:0] DOWN_LEVEL_RESET = LVL_W'(1024 * 2);
  localparam logic [LVL_W-1:0] MOVE_LEVEL_RESET = LVL_W'(1024 * 3);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd4;

  localparam logic CFG_DOWN_LEVEL = 1'b0;
  localparam logic CFG_MOVE_LEVEL = 1'b1;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  typedef struct packed {
    logic              set;
    logic              clear;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } tbl_upd_t;

  function automatic logic [FIFO_AW-1:0] next_ptr(input logic [FIFO_AW-1:0] ptr);
    next_ptr = (ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

>>> hdl/touch_point_tracker_event_queue.sv
// ----------------------------------------------------------------------------
// touch_point_tracker_event_queue
// Touch contact table feeding an event fifo with load shedding.
// ----------------------------------------------------------------------------
// Each item has a lookup cycle and an update cycle. The cycle after start is
// the lookup cycle (id match over the contact table, one read of the slot
// memory and of the event fifo memory) with busy high, then the update cycle
// writes the memories as the op needs; busy is already low there, so the next
// item can start on that edge. The result appears on the cycle after the
// update cycle with done high for that one cycle only; it must be taken then.
// No clearing pass is needed after reset. cfg_ready is always high; write
// the levels while idle.
module touch_point_tracker_event_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [tptevq_pkg::ID_W-1:0]        contact_id,
  input  logic signed [15:0]                 pos_x,
  input  logic signed [15:0]                 pos_y,
  input  logic                               from_mouse,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [tptevq_pkg::LVL_W-1:0]       cfg_data,
  output logic                               done,
  output logic [tptevq_pkg::STAT_W-1:0]      status,
  output logic                               event_valid,
  output logic [tptevq_pkg::ID_W-1:0]        event_id,
  output logic signed [15:0]                 event_x,
  output logic signed [15:0]                 event_y,
  output logic [tptevq_pkg::KIND_W-1:0]      event_kind,
  output logic                               event_mouse,
  output logic [tptevq_pkg::CNT_W-1:0]       fifo_level
);
  import tptevq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic       accept;

  logic [1:0]       op_q;
  logic [ID_W-1:0]  id_q;
  logic [POS_W-1:0] pos_q;
  logic             mouse_q;
  lookup_t          look;
  lookup_t          look_q;

  logic [LVL_W-1:0]   down_lvl;
  logic [LVL_W-1:0]   move_lvl;
  logic [FIFO_AW-1:0] head, head_next;
  logic [FIFO_AW-1:0] tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;

  tbl_upd_t             upd;
  logic                 slot_we;
  logic [SLOT_RAM_W-1:0] slot_wdata, slot_rdata;
  logic                 fifo_we;
  logic [FIFO_RAM_W-1:0] fifo_wdata, fifo_rdata;

  logic [STAT_W-1:0] status_next;
  logic              ev_valid_next;
  logic [ID_W-1:0]   ev_id_next;
  logic [POS_W-1:0]  ev_pos_next;
  logic [KIND_W-1:0] ev_kind_next;
  logic              ev_mouse_next;

  logic              offer;
  logic              admit;
  logic [KIND_W-1:0] off_kind;
  logic [POS_W-1:0]  off_pos;
  logic              off_mouse;

  assign busy      = (state == ST_LOOK);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: state <= start ? ST_LOOK : ST_IDLE;
        ST_LOOK: state <= ST_DONE;
        ST_DONE: state <= start ? ST_LOOK : ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_lvl <= DOWN_LEVEL_RESET;
      move_lvl <= MOVE_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DOWN_LEVEL) begin
        down_lvl <= cfg_data;
      end else begin
        move_lvl <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      id_q    <= contact_id;
      pos_q   <= {pos_y, pos_x};
      mouse_q <= from_mouse;
    end
    if (state == ST_LOOK) begin
      look_q <= look;
    end
  end

  tptevq_table u_table (
    .clk  (clk),
    .rst  (rst),
    .key  (id_q),
    .upd  (upd),
    .look (look)
  );

  tptevq_ram #(.WIDTH(SLOT_RAM_W), .DEPTH(MAX_CONTACTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (look_q.slot),
    .wdata (slot_wdata),
    .raddr (look.slot),
    .rdata (slot_rdata)
  );

  tptevq_ram #(.WIDTH(FIFO_RAM_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (fifo_wdata),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  // pick the event that this item offers to the fifo
  always_comb begin
    offer     = 1'b0;
    off_kind  = KIND_DOWN;
    off_pos   = pos_q;
    off_mouse = mouse_q;
    if (op_q == OP_WRITE) begin
      offer    = look_q.hit || !look_q.full;
      off_kind = look_q.hit ? KIND_MOVE : KIND_DOWN;
    end else if (op_q == OP_REMOVE) begin
      offer     = look_q.hit;
      off_kind  = KIND_UP;
      off_pos   = slot_rdata[POS_W-1:0];
      off_mouse = slot_rdata[POS_W];
    end
  end

  // shed load: drop downs above the first level, moves above both levels, anything when full
  always_comb begin
    if (count > down_lvl) begin
      case (off_kind)
        KIND_DOWN: admit = 1'b0;
        KIND_MOVE: admit = (count <= move_lvl);
        default:   admit = 1'b1;
      endcase
    end else begin
      admit = 1'b1;
    end
    if (count >= CNT_W'(FIFO_DEPTH)) begin
      admit = 1'b0;
    end
  end

  always_comb begin
    upd           = '0;
    upd.slot      = look_q.slot;
    upd.id        = id_q;
    slot_we       = 1'b0;
    slot_wdata    = {mouse_q, pos_q};
    fifo_we       = 1'b0;
    fifo_wdata    = {off_mouse, off_kind, off_pos, id_q};
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    status_next   = STAT_OK;
    ev_valid_next = 1'b0;
    ev_id_next    = '0;
    ev_pos_next   = '0;
    ev_kind_next  = '0;
    ev_mouse_next = 1'b0;
    if (state == ST_DONE) begin
      case (op_q)
        OP_WRITE: begin
          if (look_q.hit) begin
            slot_we    = 1'b1;
            // keep the stored mouse flag on a move
            slot_wdata = {slot_rdata[POS_W], pos_q};
          end else if (!look_q.full) begin
            slot_we  = 1'b1;
            upd.set  = 1'b1;
          end else begin
            status_next = STAT_TABLE_FULL;
          end
        end
        OP_REMOVE: begin
          if (look_q.hit) begin
            upd.clear = 1'b1;
          end else begin
            status_next = STAT_NOT_FOUND;
          end
        end
        OP_POP: begin
          if (count == '0) begin
            status_next = STAT_EMPTY;
          end else begin
            ev_valid_next = 1'b1;
            ev_id_next    = fifo_rdata[ID_W-1:0];
            ev_pos_next   = fifo_rdata[ID_W +: POS_W];
            ev_kind_next  = fifo_rdata[ID_W + POS_W +: KIND_W];
            ev_mouse_next = fifo_rdata[FIFO_RAM_W-1];
            head_next     = next_ptr(head);
            count_next    = count - 1'b1;
          end
        end
        default: begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end
      endcase
      if (offer) begin
        if (admit) begin
          fifo_we    = 1'b1;
          tail_next  = next_ptr(tail);
          count_next = count + 1'b1;
        end else begin
          status_next = STAT_DROPPED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= (state == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      status      <= status_next;
      event_valid <= ev_valid_next;
      event_id    <= ev_id_next;
      event_x     <= ev_pos_next[15:0];
      event_y     <= ev_pos_next[31:16];
      event_kind  <= ev_kind_next;
      event_mouse <= ev_mouse_next;
      fifo_level  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count above depth");
  a_ptr_span: assert property (@(posedge clk) disable iff (rst)
    FIFO_AW'(tail - head) == count[FIFO_AW-1:0])
    else $error("fifo pointers disagree with count");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK |=> state == ST_DONE ##1 done)
    else $error("result not strobed two cycles after lookup");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    done && event_valid |-> status == STAT_OK && $past(op_q == OP_POP))
    else $error("event carried by a result that is not a good pop");
`endif

endmodule

>>> hdl/tptevq_ram.sv
// ----------------------------------------------------------------------------
// tptevq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tptevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tptevq_table.sv
// ----------------------------------------------------------------------------
// tptevq_table
// Contact id table: valid bits and ids, parallel id match and free slot pick.
// ----------------------------------------------------------------------------
module tptevq_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tptevq_pkg::ID_W-1:0]  key,
  input  tptevq_pkg::tbl_upd_t         upd,
  output tptevq_pkg::lookup_t          look
);
  import tptevq_pkg::*;

  logic [MAX_CONTACTS-1:0] slot_valid;
  logic [ID_W-1:0]         slot_id [MAX_CONTACTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (upd.set) begin
      slot_valid[upd.slot] <= 1'b1;
    end else if (upd.clear) begin
      slot_valid[upd.slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set) begin
      slot_id[upd.slot] <= upd.id;
    end
  end

  // lowest matching slot wins, else lowest free slot
  always_comb begin
    logic              found;
    logic              got_free;
    logic [SLOT_W-1:0] match_slot;
    logic [SLOT_W-1:0] free_slot;
    found      = 1'b0;
    got_free   = 1'b0;
    match_slot = '0;
    free_slot  = '0;
    for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_id[i] == key) begin
        found      = 1'b1;
        match_slot = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        got_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
    look.hit  = found;
    look.full = !got_free;
    look.slot = found ? match_slot : free_slot;
  end

`ifndef NO_ASSERTIONS
  a_set_free: assert property (@(posedge clk) disable iff (rst)
    upd.set |-> !slot_valid[upd.slot])
    else $error("contact added over an occupied slot");
  a_clear_used: assert property (@(posedge clk) disable iff (rst)
    upd.clear |-> slot_valid[upd.slot])
    else $error("contact removed from an empty slot");
  a_set_lands: assert property (@(posedge clk) disable iff (rst)
    upd.set |=> slot_valid[$past(upd.slot)])
    else $error("added contact not marked valid");
`endif

endmodule
